// ----- hdl/ptct_pkg.sv -----
`timescale 1ns / 1ps

package ptct_pkg;

  // request codes
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_QUERY  = 2'd3;

  // result kinds
  localparam logic KIND_FIRE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // summary status codes
  localparam logic [2:0] STAT_OK     = 3'd0;
  localparam logic [2:0] STAT_DUP    = 3'd1;
  localparam logic [2:0] STAT_ABSENT = 3'd2;
  localparam logic [2:0] STAT_FULL   = 3'd3;
  localparam logic [2:0] STAT_STEPS  = 3'd4;

  localparam logic [30:0] DUE_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] task_id;
    logic [30:0] period;
    logic [30:0] steps;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] fired_id;
    logic [30:0] next_due;
    logic        found;
    logic [2:0]  status;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [15:0] id;
    logic [30:0] period;
    logic [30:0] counter;
  } entry_t;

endpackage

// ----- hdl/periodic_task_countdown_table.sv -----
`timescale 1ns / 1ps

// channel  direction  payload          handshake
// req      in         ptct_pkg::req_t  req_valid / req_stall
// res      out        ptct_pkg::res_t  res_valid / res_stall
//
// every request walks the table once, with one read per entry through the
// single read port of the table ram
// a fire or the summary waits on res_stall; the summary is always the last item
// reset clears the entry count and the output valid; table contents need no clear
// a new request is taken only once the previous summary is in the output register

module periodic_task_countdown_table #(
  parameter int SLOTS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  ptct_pkg::req_t req,
  output logic           res_valid,
  input  logic           res_stall,
  output ptct_pkg::res_t res
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  ptct_pkg::req_t   cur;
  logic [IW-1:0]    proc_idx;
  logic [CW-1:0]    ent_count;
  logic [30:0]      min_due;
  logic             found;
  logic             over_steps;

  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  ptct_pkg::entry_t rd_data;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  ptct_pkg::entry_t wr_data;

  logic             load;
  ptct_pkg::res_t   load_data;

  logic             is_tick;
  logic             is_add;
  logic             is_remove;
  logic             is_query;
  logic             match;
  logic             fire;
  logic [30:0]      new_cnt;
  logic [30:0]      cand;
  logic             excl;
  logic             out_busy;
  logic             advance;
  logic [CW-1:0]    nxt_idx;
  logic             more;
  logic             add_ok;
  logic [2:0]       sum_status;

  ptct_ram #(.SLOTS(SLOTS)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign is_tick   = (cur.req_type == ptct_pkg::REQ_TICK);
  assign is_add    = (cur.req_type == ptct_pkg::REQ_ADD);
  assign is_remove = (cur.req_type == ptct_pkg::REQ_REMOVE);
  assign is_query  = (cur.req_type == ptct_pkg::REQ_QUERY);

  assign match   = (rd_data.id == cur.task_id);
  assign fire    = is_tick && (rd_data.counter <= cur.steps);
  assign new_cnt = fire ? rd_data.period : (rd_data.counter - cur.steps);
  assign cand    = is_tick ? new_cnt : rd_data.counter;
  // the entry being removed does not count toward the minimum
  assign excl    = is_remove && match && !found;

  assign out_busy = res_valid && res_stall;
  assign nxt_idx  = CW'(proc_idx) + CW'(1);
  assign more     = (nxt_idx < ent_count);
  assign add_ok   = is_add && !found && (ent_count != CW'(SLOTS));

  always_comb begin
    sum_status = ptct_pkg::STAT_OK;
    case (cur.req_type)
      ptct_pkg::REQ_TICK: begin
        if (over_steps) sum_status = ptct_pkg::STAT_STEPS;
      end
      ptct_pkg::REQ_ADD: begin
        if (found) sum_status = ptct_pkg::STAT_DUP;
        else if (ent_count == CW'(SLOTS)) sum_status = ptct_pkg::STAT_FULL;
      end
      ptct_pkg::REQ_REMOVE: begin
        if (!found) sum_status = ptct_pkg::STAT_ABSENT;
      end
      default: begin
        sum_status = ptct_pkg::STAT_OK;
      end
    endcase
  end

  always_comb begin
    advance = 1'b0;
    case (state)
      ST_SCAN:   advance = !(fire && out_busy);
      ST_FINISH: advance = !out_busy;
      default:   advance = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    req_stall  = (state != ST_IDLE);
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = proc_idx;
    wr_data    = rd_data;
    load       = 1'b0;
    load_data  = '0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          rd_en      = 1'b1;
          rd_addr    = '0;
          state_next = (ent_count == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (advance) begin
          if (is_tick) begin
            wr_en           = 1'b1;
            wr_data.counter = new_cnt;
          end
          if (fire) begin
            load               = 1'b1;
            load_data.kind     = ptct_pkg::KIND_FIRE;
            load_data.fired_id = rd_data.id;
          end
          // entries behind the removed one move down by one slot
          if (is_remove && found) begin
            wr_en   = 1'b1;
            wr_addr = proc_idx - IW'(1);
          end
          if (more) begin
            rd_en   = 1'b1;
            rd_addr = nxt_idx[IW-1:0];
          end
          state_next = more ? ST_SCAN : ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (advance) begin
          load               = 1'b1;
          load_data.kind     = ptct_pkg::KIND_SUMMARY;
          load_data.next_due = add_ok ? 31'd1 : min_due;
          load_data.found    = is_query && found;
          load_data.status   = sum_status;
          load_data.last     = 1'b1;
          if (add_ok) begin
            wr_en          = 1'b1;
            wr_addr        = ent_count[IW-1:0];
            wr_data.id     = cur.task_id;
            wr_data.period = (cur.period == '0) ? 31'd1 : cur.period;
            wr_data.counter = 31'd1;
          end
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ent_count <= '0;
    end else begin
      state <= state_next;
      if (state == ST_FINISH && advance) begin
        if (add_ok) begin
          ent_count <= ent_count + CW'(1);
        end else if (is_remove && found) begin
          ent_count <= ent_count - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) begin
      cur        <= req;
      proc_idx   <= '0;
      min_due    <= ptct_pkg::DUE_MAX;
      found      <= 1'b0;
      over_steps <= 1'b0;
    end else if (state == ST_SCAN && advance) begin
      proc_idx <= nxt_idx[IW-1:0];
      if (match) found <= 1'b1;
      if (is_tick && (cur.steps > rd_data.period)) over_steps <= 1'b1;
      if (!excl && (cand < min_due)) min_due <= cand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_valid && !res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= load_data;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    ent_count <= CW'(SLOTS))
    else $error("entry count above table size");

  a_scan_index: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (CW'(proc_idx) < ent_count))
    else $error("scan index beyond entry count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> !out_busy)
    else $error("output register overwritten while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state != ST_IDLE))
    else $error("request accepted without starting a pass");

  a_count_stable_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |=> $stable(ent_count))
    else $error("entry count changed during a scan");

endmodule

// ----- hdl/ptct_ram.sv -----
`timescale 1ns / 1ps

module ptct_ram #(
  parameter int SLOTS = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] waddr,
  input  ptct_pkg::entry_t                      wdata,
  input  logic                                  re,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] raddr,
  output ptct_pkg::entry_t                      rdata
);

  ptct_pkg::entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
